### hdl/thermal_led_brightness_slewer_assert.svh
// Assertion macros shared by the slewer RTL.
`ifndef THERMAL_LED_BRIGHTNESS_SLEWER_ASSERT_SVH
`define THERMAL_LED_BRIGHTNESS_SLEWER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TLBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLBS_ASSERT(lbl, prop, msg)
`define TLBS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hdl/tlbs_pkg.sv
package tlbs_pkg;

  localparam int LEVEL_W   = 8;
  localparam int TEMP_W    = 8;
  localparam int TGT_W     = 2 * LEVEL_W;
  localparam int DIV_STEPS = TGT_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 1'b1;

  localparam logic [TEMP_W-1:0] LOW_THR_RST  = 8'd52;
  localparam logic [TEMP_W-1:0] HIGH_THR_RST = 8'd62;

  localparam logic [TGT_W-1:0] JUMP_GAP  = 16'd120;
  localparam logic [TGT_W-1:0] TIER_HIGH = 16'd40;
  localparam logic [TGT_W-1:0] TIER_MID  = 16'd20;
  localparam logic [TGT_W-1:0] TIER_LOW  = 16'd10;
  localparam logic [TGT_W-1:0] FULL_TGT  = 16'd255;

  localparam logic [LEVEL_W-1:0] STEP_HIGH  = 8'd10;
  localparam logic [LEVEL_W-1:0] STEP_MID   = 8'd5;
  localparam logic [LEVEL_W-1:0] STEP_LOW   = 8'd2;
  localparam logic [LEVEL_W-1:0] STEP_MIN   = 8'd1;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } tlbs_state_t;

endpackage

### hdl/thermal_led_brightness_slewer.sv
// Thermal LED brightness slewer.
// Input channel (in_valid/in_ready) takes one item: a temperature and a
// reading_ok flag. Output channel (out_valid/out_ready) returns one item per
// input: the LED level after the step, whether it was recomputed, and the
// short/long re-poll delay select (level nonzero).
// The config channel (cfg_valid/cfg_ready, always ready) writes the low
// threshold (index 0) and high threshold (index 1); write only while idle.
// A valid reading above the low threshold with ordered thresholds runs a
// bit-serial restoring divider, one quotient bit per cycle over 16 quotient
// bits; the block then passes through ST_FIN into the output register and
// returns to idle for the next item. Invalid readings and readings that need
// no divide go from idle through ST_FIN straight into the output register.
// The next item is accepted once the previous one has reached the output
// register, even while that result still waits for out_ready; a stalled
// receiver holds the block in its final state until the register frees.
// Reset (rst_n low, synchronous) clears the level to 0, restores thresholds
// to 52 and 62 and empties the output register.
module thermal_led_brightness_slewer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tlbs_pkg::TEMP_W-1:0]      in_temperature,
  input  logic                             in_reading_ok,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tlbs_pkg::LEVEL_W-1:0]     out_led_level,
  output logic                             out_level_updated,
  output logic                             out_short_delay,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tlbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tlbs_pkg::TEMP_W-1:0]      cfg_data
);
  import tlbs_pkg::*;

  tlbs_state_t          state_r, state_nxt;
  logic [TEMP_W-1:0]    low_thr_r, high_thr_r;
  logic [LEVEL_W-1:0]   level_r, level_nxt;
  logic                 ok_r;
  logic [TGT_W-1:0]     target_r;
  logic                 out_valid_r;
  logic [LEVEL_W-1:0]   out_level_r;
  logic                 out_updated_r;
  logic                 out_short_r;

  logic                 in_fire;
  logic                 above;
  logic                 ordered;
  logic [TEMP_W-1:0]    excess;
  logic [TGT_W-1:0]     numer;
  logic [LEVEL_W-1:0]   denom;
  logic                 div_start;
  logic                 div_done;
  logic [TGT_W-1:0]     quot;
  logic                 out_free;
  logic                 fin_fire;
  logic [LEVEL_W-1:0]   slew_level;

  assign above   = in_temperature > low_thr_r;
  assign ordered = high_thr_r > low_thr_r;
  assign excess  = in_temperature - low_thr_r;
  assign numer   = {excess, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, excess};
  assign denom   = high_thr_r - low_thr_r;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = div_start ? ST_DIV : ST_FIN;
      ST_DIV:  if (div_done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    fin_fire = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_DIV:  in_ready = 1'b0;
      ST_FIN:  fin_fire = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  assign in_fire   = in_valid && in_ready;
  assign div_start = in_fire && in_reading_ok && above && ordered;
  assign cfg_ready = 1'b1;
  assign level_nxt = (fin_fire && ok_r) ? slew_level : level_r;

  tlbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (numer),
    .denom (denom),
    .done  (div_done),
    .quot  (quot)
  );

  tlbs_slew u_slew (
    .target    (target_r),
    .level     (level_r),
    .new_level (slew_level)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      low_thr_r   <= LOW_THR_RST;
      high_thr_r  <= HIGH_THR_RST;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LOW_THR:  low_thr_r  <= cfg_data;
          CFG_HIGH_THR: high_thr_r <= cfg_data;
          default:      low_thr_r  <= low_thr_r;
        endcase
      end
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ok_r     <= in_reading_ok;
      target_r <= above ? FULL_TGT : '0;
    end else if (div_done) begin
      target_r <= quot;
    end
    if (fin_fire) begin
      out_level_r   <= level_nxt;
      out_updated_r <= ok_r;
      out_short_r   <= level_nxt != '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_led_level     = out_level_r;
  assign out_level_updated = out_updated_r;
  assign out_short_delay   = out_short_r;

`include "thermal_led_brightness_slewer_assert.svh"
  `TLBS_ASSERT(a_out_level, out_valid_r |-> out_level_r == level_r, "output level not stored level")
  `TLBS_ASSERT(a_out_short, out_valid_r |-> out_short_r == (out_level_r != '0), "delay select mismatch")
  `TLBS_ASSERT(a_div_state, div_done |-> state_r == ST_DIV, "divider done outside divide state")
  `TLBS_ASSERT(a_fin_load, state_r == ST_FIN && !out_valid_r |=> out_valid_r, "result not loaded")
endmodule

### hdl/tlbs_div.sv
module tlbs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tlbs_pkg::TGT_W-1:0]  numer,
  input  logic [tlbs_pkg::LEVEL_W-1:0] denom,
  output logic                        done,
  output logic [tlbs_pkg::TGT_W-1:0]  quot
);
  import tlbs_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TGT_W-1:0]     num_r, num_nxt;
  logic [LEVEL_W-1:0]   rem_r, rem_nxt;
  logic [LEVEL_W-1:0]   den_r, den_nxt;
  logic [LEVEL_W:0]     trial;
  logic                 ge;

  // one quotient bit per cycle; quotient bits shift into the numerator register
  always_comb begin
    trial    = {rem_r, num_r[TGT_W-1]};
    ge       = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = numer;
      rem_nxt  = '0;
      den_nxt  = denom;
    end else if (busy_r) begin
      num_nxt = {num_r[TGT_W-2:0], ge};
      rem_nxt = ge ? LEVEL_W'(trial - {1'b0, den_r}) : trial[LEVEL_W-1:0];
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        cnt_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = num_r;

`include "thermal_led_brightness_slewer_assert.svh"
  `TLBS_ASSERT(a_start_busy, start && !busy_r |=> busy_r, "divider did not start")
  `TLBS_ASSERT(a_done_idle, done_r |-> !busy_r, "divider busy while done")
  `TLBS_ASSERT(a_idle_cnt, !busy_r |-> cnt_r == '0, "divider count not cleared")
endmodule

### hdl/tlbs_slew.sv
module tlbs_slew (
  input  logic [tlbs_pkg::TGT_W-1:0]   target,
  input  logic [tlbs_pkg::LEVEL_W-1:0] level,
  output logic [tlbs_pkg::LEVEL_W-1:0] new_level
);
  import tlbs_pkg::*;

  logic signed [TGT_W:0] gap;
  logic [TGT_W:0]        neg;
  logic [TGT_W-1:0]      mag;
  logic [TGT_W-1:0]      lvl_ext;
  logic [TGT_W-1:0]      step_ext;
  logic [LEVEL_W-1:0]    step;
  logic [TGT_W-1:0]      raw;

  always_comb begin
    lvl_ext = {{(TGT_W-LEVEL_W){1'b0}}, level};
    gap     = $signed({1'b0, target}) - $signed({1'b0, lvl_ext});
    neg     = -gap;
    mag     = gap[TGT_W] ? neg[TGT_W-1:0] : gap[TGT_W-1:0];
    if (mag > TIER_HIGH) begin
      step = STEP_HIGH;
    end else if (mag > TIER_MID) begin
      step = STEP_MID;
    end else if (mag > TIER_LOW) begin
      step = STEP_LOW;
    end else begin
      step = STEP_MIN;
    end
    step_ext = {{(TGT_W-LEVEL_W){1'b0}}, step};
    if (mag > JUMP_GAP) begin
      raw = target;
    end else if (mag == '0) begin
      raw = lvl_ext;
    end else if (gap[TGT_W]) begin
      raw = lvl_ext - step_ext;
    end else begin
      raw = lvl_ext + step_ext;
    end
    new_level = (raw > FULL_TGT) ? FULL_LEVEL : raw[LEVEL_W-1:0];
  end
endmodule
